>>> hw/rtl/tbr_pkg.sv
// ----------------------------------------------------------------------------
// tbr_pkg: shared constants, types and helpers
// Widths, command/status bundles and arithmetic helpers for the rasterizer.
// ----------------------------------------------------------------------------
package tbr_pkg;

  localparam int COORD_FRAC_BITS  = 4;
  localparam int WEIGHT_FRAC_BITS = 24;
  localparam int MAX_TRIANGLES    = 1024;

  localparam int PIX_W   = 12;
  localparam int CFG_W   = 13;
  localparam int TRI_W   = 10;
  localparam int CRD_W   = 16;
  localparam int WGT_W   = 32;
  localparam int ACC_W   = 40;
  localparam int MA_W    = CRD_W + 1;
  localparam int MB_W    = (PIX_W + 1 + COORD_FRAC_BITS > MA_W) ?
                           PIX_W + 1 + COORD_FRAC_BITS : MA_W;
  localparam int BOX_W   = CRD_W + 2;
  localparam int TERM_W  = 4;
  localparam int PIX_LIMIT = 4096;

  localparam logic [TERM_W-1:0] TERM_LAST = TERM_W'(15);

  // input command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // register select (address bit 2)
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // division target kinds
  localparam logic [1:0] KIND_GX = 2'd0;
  localparam logic [1:0] KIND_GY = 2'd1;
  localparam logic [1:0] KIND_N  = 2'd2;

  localparam logic signed [WGT_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [WGT_W-1:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [WGT_W-1:0] ONE_W   = WGT_W'(64'd1 << WEIGHT_FRAC_BITS);

  typedef struct packed {
    logic              load;
    logic              step;
    logic              box;
    logic              mac;
    logic [TERM_W-1:0] term;
    logic              div_start;
    logic              div_store;
    logic [1:0]        lane;
    logic [1:0]        kind;
  } cmd_t;

  typedef struct packed {
    logic box_empty;
    logic area_zero;
    logic div_done;
  } sts_t;

  function automatic logic [1:0] rot_a(input logic [1:0] k);
    logic [1:0] r;
    case (k)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] rot_b(input logic [1:0] k);
    logic [1:0] r;
    case (k)
      2'd0:    r = 2'd2;
      2'd1:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  function automatic logic signed [WGT_W-1:0] sat_add(
      input logic signed [WGT_W-1:0] a, input logic signed [WGT_W-1:0] b);
    logic signed [WGT_W:0] s;
    logic signed [WGT_W-1:0] r;
    s = (WGT_W+1)'(a) + (WGT_W+1)'(b);
    if (s[WGT_W] != s[WGT_W-1]) begin
      r = s[WGT_W] ? S32_MIN : S32_MAX;
    end else begin
      r = s[WGT_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/tbr_in_if.sv
// ----------------------------------------------------------------------------
// tbr_in_if: request channel into the rasterizer
// Valid/ready handshake carrying a load or step request.
// ----------------------------------------------------------------------------
interface tbr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 command;
  logic signed [tbr_pkg::CRD_W-1:0]     vert0_x;
  logic signed [tbr_pkg::CRD_W-1:0]     vert0_y;
  logic signed [tbr_pkg::CRD_W-1:0]     vert1_x;
  logic signed [tbr_pkg::CRD_W-1:0]     vert1_y;
  logic signed [tbr_pkg::CRD_W-1:0]     vert2_x;
  logic signed [tbr_pkg::CRD_W-1:0]     vert2_y;
  logic [tbr_pkg::TRI_W-1:0]            tri_index;

  modport source (output valid, command, vert0_x, vert0_y, vert1_x, vert1_y,
                  vert2_x, vert2_y, tri_index, input ready);
  modport sink (input valid, command, vert0_x, vert0_y, vert1_x, vert1_y,
                vert2_x, vert2_y, tri_index, output ready);
endinterface

>>> hw/rtl/tbr_out_if.sv
// ----------------------------------------------------------------------------
// tbr_out_if: pixel result channel
// Valid/ready handshake carrying one scanned pixel.
// ----------------------------------------------------------------------------
interface tbr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 covered;
  logic [tbr_pkg::PIX_W-1:0]            pixel_x;
  logic [tbr_pkg::PIX_W-1:0]            pixel_y;
  logic signed [tbr_pkg::WGT_W-1:0]     weight0;
  logic signed [tbr_pkg::WGT_W-1:0]     weight1;
  logic signed [tbr_pkg::WGT_W-1:0]     weight2;
  logic [tbr_pkg::TRI_W-1:0]            owner_triangle;
  logic                                 box_done;

  modport source (output valid, covered, pixel_x, pixel_y, weight0, weight1,
                  weight2, owner_triangle, box_done, input ready);
  modport sink (input valid, covered, pixel_x, pixel_y, weight0, weight1,
                weight2, owner_triangle, box_done, output ready);
endinterface

>>> hw/rtl/triangle_barycentric_rasterizer_top.sv
// Step request: result registered in the cycle after acceptance; steps accepted
//   every cycle while idle and the result register drains.
// Load request: no result; the block is busy through a box step, a multiply-
//   accumulate phase and 9 divisions in the shared serial divider; a zero-area
//   triangle ends after the multiply-accumulate phase, an empty box after the box step.
// Reset (rst_n low, synchronous): no scan active, image 640 x 480.
// ----------------------------------------------------------------------------
// triangle_barycentric_rasterizer_top: barycentric triangle rasterizer
// Triangle setup from three vertices, then one pixel with lambdas per step.
// ----------------------------------------------------------------------------
module triangle_barycentric_rasterizer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  tbr_in_if.sink                        in_ch,
  tbr_out_if.source                     out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [2:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import tbr_pkg::*;

  logic [CFG_W-1:0] img_w_r, img_h_r;
  cmd_t cmd;
  sts_t sts;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= CFG_W'(640);
      img_h_r <= CFG_W'(480);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (cfg_paddr[2])
        REG_WIDTH:  img_w_r <= cfg_pwdata[CFG_W-1:0];
        REG_HEIGHT: img_h_r <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_HEIGHT) ? 32'(img_h_r) : 32'(img_w_r);

  tbr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  tbr_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .img_w     (img_w_r),
    .img_h     (img_h_r),
    .v0x       (in_ch.vert0_x),
    .v0y       (in_ch.vert0_y),
    .v1x       (in_ch.vert1_x),
    .v1y       (in_ch.vert1_y),
    .v2x       (in_ch.vert2_x),
    .v2y       (in_ch.vert2_y),
    .tri_in    (in_ch.tri_index),
    .o_covered (out_ch.covered),
    .o_px      (out_ch.pixel_x),
    .o_py      (out_ch.pixel_y),
    .o_w0      (out_ch.weight0),
    .o_w1      (out_ch.weight1),
    .o_w2      (out_ch.weight2),
    .o_owner   (out_ch.owner_triangle),
    .o_done    (out_ch.box_done)
  );

endmodule

>>> hw/rtl/tbr_div.sv
// ----------------------------------------------------------------------------
// tbr_div: iterative fixed-point divider
// Computes num * 2^W / den, truncated toward zero, saturated to 32 bits.
// One quotient bit per cycle after a saturation check.
// ----------------------------------------------------------------------------
module tbr_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [tbr_pkg::ACC_W-1:0]  num,
  input  logic signed [tbr_pkg::ACC_W-1:0]  den,
  output logic                              done,
  output logic signed [tbr_pkg::WGT_W-1:0]  quo
);
  import tbr_pkg::*;

  localparam int QB   = WGT_W - 1;
  localparam int EXT_W = ACC_W + WEIGHT_FRAC_BITS;
  localparam int HI_W = EXT_W - QB;
  localparam int CNT_W = $clog2(QB + 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PREP = 2'd1;
  localparam logic [1:0] PH_RUN  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic [1:0]       ph_r, ph_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             neg_r, sat_r;
  logic [ACC_W-1:0] a_r, b_r, rem_r;
  logic [QB-1:0]    low_r, q_r;
  logic [EXT_W-1:0] ext;
  logic [HI_W-1:0]  hi;
  logic [ACC_W:0]   r2, bx;
  logic             ge, hi_ge;

  assign ext   = {a_r, {WEIGHT_FRAC_BITS{1'b0}}};
  assign hi    = ext[EXT_W-1:QB];
  assign bx    = {1'b0, b_r};
  assign hi_ge = (ACC_W+1)'(hi) >= bx;
  assign r2    = {rem_r, low_r[QB-1]};
  assign ge    = r2 >= bx;

  always_comb begin
    ph_nxt  = ph_r;
    cnt_nxt = cnt_r;
    case (ph_r)
      PH_IDLE: if (start) ph_nxt = PH_PREP;
      PH_PREP: begin
        ph_nxt  = hi_ge ? PH_DONE : PH_RUN;
        cnt_nxt = CNT_W'(QB);
      end
      PH_RUN: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) ph_nxt = PH_DONE;
      end
      PH_DONE: ph_nxt = PH_IDLE;
      default: ph_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_IDLE;
      cnt_r <= '0;
    end else begin
      ph_r  <= ph_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (ph_r)
      PH_IDLE: if (start) begin
        neg_r <= num[ACC_W-1] ^ den[ACC_W-1];
        a_r   <= num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
        b_r   <= den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
      end
      PH_PREP: begin
        sat_r <= hi_ge;
        rem_r <= ACC_W'(hi);
        low_r <= ext[QB-1:0];
        q_r   <= '0;
      end
      PH_RUN: begin
        rem_r <= ge ? ACC_W'(r2 - bx) : ACC_W'(r2);
        q_r   <= {q_r[QB-2:0], ge};
        low_r <= {low_r[QB-2:0], 1'b0};
      end
      default: ;
    endcase
  end

  assign done = (ph_r == PH_DONE);

  always_comb begin
    if (sat_r) begin
      quo = neg_r ? S32_MIN : S32_MAX;
    end else if (neg_r) begin
      quo = -$signed({1'b0, q_r});
    end else begin
      quo = $signed({1'b0, q_r});
    end
  end

endmodule

>>> hw/rtl/tbr_datapath.sv
// ----------------------------------------------------------------------------
// tbr_datapath: setup arithmetic and raster walk
// Holds vertices, box, gradients and lambdas; a shared multiplier builds
// the area and lambda numerators, a shared divider the fixed-point values.
// ----------------------------------------------------------------------------
module tbr_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tbr_pkg::cmd_t                     cmd,
  output tbr_pkg::sts_t                     sts,
  input  logic [tbr_pkg::CFG_W-1:0]         img_w,
  input  logic [tbr_pkg::CFG_W-1:0]         img_h,
  input  logic signed [tbr_pkg::CRD_W-1:0]  v0x,
  input  logic signed [tbr_pkg::CRD_W-1:0]  v0y,
  input  logic signed [tbr_pkg::CRD_W-1:0]  v1x,
  input  logic signed [tbr_pkg::CRD_W-1:0]  v1y,
  input  logic signed [tbr_pkg::CRD_W-1:0]  v2x,
  input  logic signed [tbr_pkg::CRD_W-1:0]  v2y,
  input  logic [tbr_pkg::TRI_W-1:0]         tri_in,
  output logic                              o_covered,
  output logic [tbr_pkg::PIX_W-1:0]         o_px,
  output logic [tbr_pkg::PIX_W-1:0]         o_py,
  output logic signed [tbr_pkg::WGT_W-1:0]  o_w0,
  output logic signed [tbr_pkg::WGT_W-1:0]  o_w1,
  output logic signed [tbr_pkg::WGT_W-1:0]  o_w2,
  output logic [tbr_pkg::TRI_W-1:0]         o_owner,
  output logic                              o_done
);
  import tbr_pkg::*;

  logic signed [CRD_W-1:0] vx_r [3];
  logic signed [CRD_W-1:0] vy_r [3];
  logic [TRI_W-1:0]        tri_r;
  logic [PIX_W-1:0]        bminx_r, bminy_r, bmaxx_r, bmaxy_r, curx_r, cury_r;
  logic signed [WGT_W-1:0] roww_r [3];
  logic signed [WGT_W-1:0] curw_r [3];
  logic signed [WGT_W-1:0] gx_r [3];
  logic signed [WGT_W-1:0] gy_r [3];
  logic                    scan_r, degen_r;
  logic signed [ACC_W-1:0] prod_r, acc_r, area_r;
  logic signed [ACC_W-1:0] num_r [3];
  logic signed [ACC_W-1:0] acc_nxt;

  logic signed [MA_W-1:0]  ex [3];
  logic signed [MA_W-1:0]  ey [3];

  logic [TRI_W-1:0] tri_mod;
  assign tri_mod = (MAX_TRIANGLES >= (1 << TRI_W)) ? tri_in :
                   TRI_W'(32'(tri_in) % MAX_TRIANGLES);

  for (genvar k = 0; k < 3; k++) begin : g_edge
    assign ex[k] = MA_W'(vy_r[rot_a(2'(k))]) - MA_W'(vy_r[rot_b(2'(k))]);
    assign ey[k] = MA_W'(vx_r[rot_b(2'(k))]) - MA_W'(vx_r[rot_a(2'(k))]);
  end

  // ---- bounding box ----
  logic signed [CRD_W-1:0] mnx, mny, mxx, mxy;
  logic signed [BOX_W-1:0] lox, loy, hix, hiy, limx, limy, flx, fly;
  logic [CFG_W-1:0]        szx, szy;

  always_comb begin
    mnx = vx_r[0];
    mxx = vx_r[0];
    mny = vy_r[0];
    mxy = vy_r[0];
    for (int i = 1; i < 3; i++) begin
      if (vx_r[i] < mnx) mnx = vx_r[i];
      if (vx_r[i] > mxx) mxx = vx_r[i];
      if (vy_r[i] < mny) mny = vy_r[i];
      if (vy_r[i] > mxy) mxy = vy_r[i];
    end
    szx  = (img_w > CFG_W'(PIX_LIMIT)) ? CFG_W'(PIX_LIMIT) : img_w;
    szy  = (img_h > CFG_W'(PIX_LIMIT)) ? CFG_W'(PIX_LIMIT) : img_h;
    limx = $signed(BOX_W'(szx)) - BOX_W'(1);
    limy = $signed(BOX_W'(szy)) - BOX_W'(1);
    flx  = BOX_W'(mnx >>> COORD_FRAC_BITS);
    fly  = BOX_W'(mny >>> COORD_FRAC_BITS);
    lox  = flx[BOX_W-1] ? '0 : flx;
    loy  = fly[BOX_W-1] ? '0 : fly;
    hix  = BOX_W'(mxx >>> COORD_FRAC_BITS) + BOX_W'(1);
    hiy  = BOX_W'(mxy >>> COORD_FRAC_BITS) + BOX_W'(1);
    if (hix > limx) hix = limx;
    if (hiy > limy) hiy = limy;
  end

  assign sts.box_empty = (lox > hix) || (loy > hiy);
  assign sts.area_zero = (area_r == '0);

  // ---- multiplier operand select ----
  logic [TERM_W-1:0]       tt, tc, tcg;
  logic [1:0]              grp, part, ia, ib, cgrp;
  logic signed [MA_W-1:0]  opa;
  logic signed [MB_W-1:0]  opb, lox_b, loy_b;
  logic signed [MA_W+MB_W-1:0] prod_full;
  logic                    first, last;

  assign lox_b = $signed(MB_W'(bminx_r) << COORD_FRAC_BITS);
  assign loy_b = $signed(MB_W'(bminy_r) << COORD_FRAC_BITS);
  assign tt    = cmd.term - TERM_W'(3);
  assign grp   = tt[3:2];
  assign part  = tt[1:0];
  assign ia    = rot_a(grp);
  assign ib    = rot_b(grp);

  always_comb begin
    opa = '0;
    opb = '0;
    if (cmd.term < TERM_W'(3)) begin
      // area terms: X[k] * (Y[k+1] - Y[k+2])
      case (cmd.term[1:0])
        2'd0:    begin opa = MA_W'(vx_r[0]); opb = MB_W'(ex[0]); end
        2'd1:    begin opa = MA_W'(vx_r[1]); opb = MB_W'(ex[1]); end
        default: begin opa = MA_W'(vx_r[2]); opb = MB_W'(ex[2]); end
      endcase
    end else begin
      case (part)
        2'd0:    begin opa = ex[grp];         opb = lox_b; end
        2'd1:    begin opa = ey[grp];         opb = loy_b; end
        2'd2:    begin opa = MA_W'(vx_r[ia]); opb = MB_W'(vy_r[ib]); end
        default: begin opa = MA_W'(vx_r[ib]); opb = -MB_W'(vy_r[ia]); end
      endcase
    end
  end

  assign prod_full = opa * opb;

  assign tc    = cmd.term - TERM_W'(1);
  assign tcg   = tc - TERM_W'(3);
  assign cgrp  = tcg[3:2];
  assign first = (tc == TERM_W'(0)) || (tc == TERM_W'(3)) || (tc == TERM_W'(7)) ||
                 (tc == TERM_W'(11));
  assign last  = (tc == TERM_W'(2)) || (tc == TERM_W'(6)) || (tc == TERM_W'(10)) ||
                 (tc == TERM_W'(14));
  assign acc_nxt = (first ? ACC_W'(0) : acc_r) + prod_r;

  // ---- divider ----
  logic signed [ACC_W-1:0] div_num;
  logic signed [WGT_W-1:0] div_q;

  always_comb begin
    case (cmd.kind)
      KIND_GX: div_num = ACC_W'(ex[cmd.lane]) <<< COORD_FRAC_BITS;
      KIND_GY: div_num = ACC_W'(ey[cmd.lane]) <<< COORD_FRAC_BITS;
      default: div_num = num_r[cmd.lane];
    endcase
  end

  tbr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (area_r),
    .done  (sts.div_done),
    .quo   (div_q)
  );

  // ---- control-visible state ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r  <= 1'b0;
      degen_r <= 1'b0;
    end else if (cmd.load) begin
      scan_r  <= 1'b0;
    end else if (cmd.box) begin
      scan_r  <= !sts.box_empty;
      degen_r <= 1'b0;
    end else if (cmd.mac && cmd.term == TERM_LAST) begin
      degen_r <= sts.area_zero;
    end else if (cmd.step && scan_r && curx_r == bmaxx_r && cury_r == bmaxy_r) begin
      scan_r  <= 1'b0;
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vx_r[0] <= v0x;
      vy_r[0] <= v0y;
      vx_r[1] <= v1x;
      vy_r[1] <= v1y;
      vx_r[2] <= v2x;
      vy_r[2] <= v2y;
      tri_r   <= tri_mod;
    end

    if (cmd.box) begin
      for (int k = 0; k < 3; k++) begin
        roww_r[k] <= '0;
        curw_r[k] <= '0;
        gx_r[k]   <= '0;
        gy_r[k]   <= '0;
      end
      area_r <= '0;
      if (sts.box_empty) begin
        bminx_r <= '0;
        bminy_r <= '0;
        bmaxx_r <= '0;
        bmaxy_r <= '0;
        curx_r  <= '0;
        cury_r  <= '0;
      end else begin
        bminx_r <= PIX_W'(lox);
        bminy_r <= PIX_W'(loy);
        bmaxx_r <= PIX_W'(hix);
        bmaxy_r <= PIX_W'(hiy);
        curx_r  <= PIX_W'(lox);
        cury_r  <= PIX_W'(loy);
      end
    end

    if (cmd.mac) begin
      if (cmd.term != TERM_LAST) prod_r <= ACC_W'(prod_full);
      if (cmd.term != '0) begin
        acc_r <= acc_nxt;
        if (last) begin
          if (tc == TERM_W'(2)) area_r <= acc_nxt;
          else num_r[cgrp] <= acc_nxt;
        end
      end
    end

    if (cmd.div_store) begin
      case (cmd.kind)
        KIND_GX: gx_r[cmd.lane] <= div_q;
        KIND_GY: gy_r[cmd.lane] <= div_q;
        default: begin
          roww_r[cmd.lane] <= div_q;
          curw_r[cmd.lane] <= div_q;
        end
      endcase
    end

    if (cmd.step) begin
      if (!scan_r) begin
        o_covered <= 1'b0;
        o_px      <= '0;
        o_py      <= '0;
        o_w0      <= '0;
        o_w1      <= '0;
        o_w2      <= '0;
        o_owner   <= '0;
        o_done    <= 1'b1;
      end else begin
        o_covered <= !degen_r &&
                     !curw_r[0][WGT_W-1] && curw_r[0] <= ONE_W &&
                     !curw_r[1][WGT_W-1] && curw_r[1] <= ONE_W &&
                     !curw_r[2][WGT_W-1] && curw_r[2] <= ONE_W;
        o_px      <= curx_r;
        o_py      <= cury_r;
        o_w0      <= curw_r[0];
        o_w1      <= curw_r[1];
        o_w2      <= curw_r[2];
        o_owner   <= tri_r;
        o_done    <= (curx_r == bmaxx_r) && (cury_r == bmaxy_r);
        if (curx_r < bmaxx_r) begin
          curx_r <= curx_r + 1'b1;
          for (int k = 0; k < 3; k++) curw_r[k] <= sat_add(curw_r[k], gx_r[k]);
        end else if (cury_r < bmaxy_r) begin
          curx_r <= bminx_r;
          cury_r <= cury_r + 1'b1;
          for (int k = 0; k < 3; k++) begin
            roww_r[k] <= sat_add(roww_r[k], gy_r[k]);
            curw_r[k] <= sat_add(roww_r[k], gy_r[k]);
          end
        end
      end
    end
  end

endmodule

>>> hw/rtl/tbr_ctrl.sv
// ----------------------------------------------------------------------------
// tbr_ctrl: sequencer for triangle setup and handshakes
// Steps through box, multiply-accumulate and division phases of a load,
// and owns the request/result handshake.
// ----------------------------------------------------------------------------
module tbr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_command,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output tbr_pkg::cmd_t  cmd,
  input  tbr_pkg::sts_t  sts
);
  import tbr_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_BOX      = 3'd1;
  localparam logic [2:0] ST_MAC      = 3'd2;
  localparam logic [2:0] ST_DIV_GO   = 3'd3;
  localparam logic [2:0] ST_DIV_WAIT = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [TERM_W-1:0] term_r, term_nxt;
  logic [1:0]        lane_r, lane_nxt, kind_r, kind_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic              acc;

  assign in_ready  = (state_r == ST_IDLE) && (!ovalid_r || out_ready);
  assign acc       = in_valid && in_ready;
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    lane_nxt  = lane_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    cmd.term  = term_r;
    cmd.lane  = lane_r;
    cmd.kind  = kind_r;
    case (state_r)
      ST_IDLE: begin
        cmd.load = acc && (in_command == CMD_LOAD);
        cmd.step = acc && (in_command == CMD_STEP);
        if (cmd.load) state_nxt = ST_BOX;
      end
      ST_BOX: begin
        cmd.box  = 1'b1;
        term_nxt = '0;
        state_nxt = sts.box_empty ? ST_IDLE : ST_MAC;
      end
      ST_MAC: begin
        cmd.mac  = 1'b1;
        term_nxt = term_r + 1'b1;
        if (term_r == TERM_LAST) begin
          lane_nxt  = '0;
          kind_nxt  = KIND_GX;
          state_nxt = sts.area_zero ? ST_IDLE : ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          state_nxt     = ST_DIV_GO;
          if (kind_r == KIND_N) begin
            kind_nxt = KIND_GX;
            lane_nxt = lane_r + 1'b1;
            if (lane_r == 2'd2) state_nxt = ST_IDLE;
          end else begin
            kind_nxt = kind_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.step) ovalid_nxt = 1'b1;
    else if (out_ready) ovalid_nxt = 1'b0;
    else ovalid_nxt = ovalid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      term_r   <= '0;
      lane_r   <= '0;
      kind_r   <= KIND_GX;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      term_r   <= term_nxt;
      lane_r   <= lane_nxt;
      kind_r   <= kind_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  a_load_to_box: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_BOX)
    else $error("load request did not start box setup");

  a_store_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_store |-> sts.div_done && state_r == ST_DIV_WAIT)
    else $error("division stored without a finished quotient");

  a_div_indices: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_GO || state_r == ST_DIV_WAIT) |-> lane_r != 2'd3 && kind_r != 2'd3)
    else $error("division lane or kind out of range");

  a_step_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> ovalid_r)
    else $error("step request produced no result");

endmodule
